@@ rtl/lru2_pkg.sv @@
// Package for the two-list LRU-2 cache: command codes, search codes, sequencer
// phases and the shift codes shared by the list cells. No dependencies.
`default_nettype none
package lru2_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_VISIT  = 3'd1,
    CMD_GET    = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    WHERE_NONE = 2'd0,
    WHERE_MAIN = 2'd1,
    WHERE_HIST = 2'd2
  } where_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SEARCH = 3'd1,
    PH_STEP1  = 3'd2,
    PH_STEP2  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // Shift operation shared by every cell in a list in a given cycle; only selected cells apply it.
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_PUSH  = 2'd1,  // shift right from front up to and including pos
    OP_PULL  = 2'd2,  // shift left from pos up to last (drop at pos)
    OP_WRITE = 2'd3   // overwrite data at pos
  } op_t;

  localparam int CfgIdxLru  = 0;
  localparam int CfgIdxHist = 1;
  localparam int CfgIdxW    = 1;

endpackage
`default_nettype wire

@@ rtl/lru2_cell.sv @@
// One list cell: holds a key and data word, compares with the search key and
// takes its neighbour's (or the head's) contents on push or pull and the head data on write. Uses lru2_pkg.
`default_nettype none
module lru2_cell #(
  parameter int KW = 32,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire lru2_pkg::op_t op,
  input  wire logic          sel,      // cell takes part in the shift / write
  input  wire logic          front,    // first cell: take head data on push
  input  wire logic [KW-1:0] head_key,
  input  wire logic [DW-1:0] head_data,
  input  wire logic [KW-1:0] left_key,
  input  wire logic [DW-1:0] left_data,
  input  wire logic [KW-1:0] right_key,
  input  wire logic [DW-1:0] right_data,
  input  wire logic [KW-1:0] search_key,
  output logic               hit,
  output logic      [KW-1:0] key_q,
  output logic      [DW-1:0] data_q
);
  logic [KW-1:0] key_r, key_nxt;
  logic [DW-1:0] data_r, data_nxt;

  always_comb begin
    key_nxt  = key_r;
    data_nxt = data_r;
    if (sel) begin
      unique case (op)
        lru2_pkg::OP_PUSH: begin
          key_nxt  = front ? head_key  : left_key;
          data_nxt = front ? head_data : left_data;
        end
        lru2_pkg::OP_PULL: begin
          key_nxt  = right_key;
          data_nxt = right_data;
        end
        lru2_pkg::OP_WRITE: data_nxt = head_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

  assign hit    = (key_r == search_key);
  assign key_q  = key_r;
  assign data_q = data_r;
endmodule
`default_nettype wire

@@ rtl/lru2_list.sv @@
// A row of lru2_cell instances forming one recency list, front at cell 0.
// Produces per-cell hit flags and applies one shift operation per cycle.
`default_nettype none
module lru2_list #(
  parameter int DEPTH = 16,
  parameter int KW    = 32,
  parameter int DW    = 32,
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire lru2_pkg::op_t op,
  input  wire logic [IW-1:0] pos,
  input  wire logic [IW-1:0] last,     // highest cell that pull shifts from
  input  wire logic [KW-1:0] head_key,
  input  wire logic [DW-1:0] head_data,
  input  wire logic [KW-1:0] search_key,
  output logic [DEPTH-1:0]   hits,
  output logic [KW-1:0]      keys [DEPTH],
  output logic [DW-1:0]      datas [DEPTH]
);
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          sel;
    logic [KW-1:0] lk, rk;
    logic [DW-1:0] ld, rd;
    always_comb begin
      unique case (op)
        lru2_pkg::OP_PUSH:  sel = (IW'(i) <= pos);
        lru2_pkg::OP_PULL:  sel = (IW'(i) >= pos) && (IW'(i) < last);
        lru2_pkg::OP_WRITE: sel = (IW'(i) == pos);
        default:            sel = 1'b0;
      endcase
    end
    if (i == 0) begin : g_l0
      assign lk = head_key;
      assign ld = head_data;
    end else begin : g_l
      assign lk = keys[i-1];
      assign ld = datas[i-1];
    end
    if (i == DEPTH-1) begin : g_rn
      assign rk = keys[i];
      assign rd = datas[i];
    end else begin : g_r
      assign rk = keys[i+1];
      assign rd = datas[i+1];
    end
    lru2_cell #(.KW(KW), .DW(DW)) u_cell (
      .clk(clk), .op(op), .sel(sel), .front(i == 0),
      .head_key(head_key), .head_data(head_data),
      .left_key(lk), .left_data(ld), .right_key(rk), .right_data(rd),
      .search_key(search_key), .hit(hits[i]), .key_q(keys[i]), .data_q(datas[i])
    );
  end
endmodule
`default_nettype wire

@@ rtl/lru2_two_list_cache.sv @@
// Top level of the two-list LRU-2 cache: command sequencer, fill counters
// and two lru2_list cell rows. Uses lru2_pkg, lru2_list, lru2_cell.
//
//  channel | ports                                   | handshake
//  input   | in_command, in_item_key, in_item_data   | start & !busy
//  result  | out_found, out_found_data, out_found_where | out_valid strobe
//  config  | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// A command is taken at the edge that ends an idle cycle. Search, one apply
// phase and the strobe follow. Move-to-front and promotion add a second
// apply phase (a pull then a push). Clear and unknown commands skip apply.
// The sequencer returns to idle after the strobe. Synchronous reset empties
// both lists. The receiver cannot stall; busy stays high until the strobe
// cycle is over.
`default_nettype none
module lru2_two_list_cache #(
  parameter int LRU_DEPTH  = 16,
  parameter int HIST_DEPTH = 32,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_command,
  input  wire logic [KEY_WIDTH-1:0]  in_item_key,
  input  wire logic [DATA_WIDTH-1:0] in_item_data,
  output logic                       out_valid,
  output logic                       out_found,
  output logic [DATA_WIDTH-1:0]      out_found_data,
  output logic [1:0]                 out_found_where,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [lru2_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [5:0]            cfg_data
);
  localparam int MIW = (LRU_DEPTH > 1) ? $clog2(LRU_DEPTH) : 1;
  localparam int HIW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int MFW = $clog2(LRU_DEPTH + 1);
  localparam int HFW = $clog2(HIST_DEPTH + 1);

  lru2_pkg::phase_t phase_r, phase_nxt;
  logic [4:0] lru_limit_r;
  logic [5:0] hist_limit_r;
  logic [2:0] cmd_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [DATA_WIDTH-1:0] dat_r;
  logic [MFW-1:0] mfill_r, mfill_nxt;
  logic [HFW-1:0] hfill_r, hfill_nxt;
  logic mhit_r, hhit_r;
  logic [MIW-1:0] mi_r;
  logic [HIW-1:0] hi_r;
  logic [KEY_WIDTH-1:0]  mv_key_r;
  logic [DATA_WIDTH-1:0] mv_data_r;
  logic found_r, found_nxt;
  logic [DATA_WIDTH-1:0] fdata_r, fdata_nxt;
  logic [1:0] where_r, where_nxt;

  lru2_pkg::op_t mop, hop;
  logic [MIW-1:0] mpos, mlast;
  logic [HIW-1:0] hpos, hlast;
  logic [KEY_WIDTH-1:0]  mhk;
  logic [DATA_WIDTH-1:0] mhd, hhd;
  logic [LRU_DEPTH-1:0]  mhits;
  logic [HIST_DEPTH-1:0] hhits;
  logic [KEY_WIDTH-1:0]  mkeys [LRU_DEPTH];
  logic [DATA_WIDTH-1:0] mdatas [LRU_DEPTH];
  logic [KEY_WIDTH-1:0]  hkeys [HIST_DEPTH];
  logic [DATA_WIDTH-1:0] hdatas [HIST_DEPTH];

  // Effective limits: zero reads as one, saturate to the depth.
  logic [MFW:0] mlim;
  logic [HFW:0] hlim;
  always_comb begin
    if (lru_limit_r == 5'd0) mlim = (MFW+1)'(1);
    else if (32'(lru_limit_r) > LRU_DEPTH) mlim = (MFW+1)'(LRU_DEPTH);
    else mlim = (MFW+1)'(lru_limit_r);
    if (hist_limit_r == 6'd0) hlim = (HFW+1)'(1);
    else if (32'(hist_limit_r) > HIST_DEPTH) hlim = (HFW+1)'(HIST_DEPTH);
    else hlim = (HFW+1)'(hist_limit_r);
  end

  // First hit from the front among valid cells.
  logic mfound, hfound;
  logic [MIW-1:0] mfirst;
  logic [HIW-1:0] hfirst;
  always_comb begin
    mfound = 1'b0;
    mfirst = '0;
    for (int i = LRU_DEPTH-1; i >= 0; i--) begin
      if (mhits[i] && (MFW'(i) < mfill_r)) begin
        mfound = 1'b1;
        mfirst = MIW'(i);
      end
    end
    hfound = 1'b0;
    hfirst = '0;
    for (int i = HIST_DEPTH-1; i >= 0; i--) begin
      if (hhits[i] && (HFW'(i) < hfill_r)) begin
        hfound = 1'b1;
        hfirst = HIW'(i);
      end
    end
  end

  logic [MFW-1:0] mfill_room;   // fill after make_room
  logic [HFW-1:0] hfill_room;
  assign mfill_room = ((MFW+1)'(mfill_r) >= mlim && mfill_r != '0) ? mfill_r - 1'b1 : mfill_r;
  assign hfill_room = ((HFW+1)'(hfill_r) >= hlim && hfill_r != '0) ? hfill_r - 1'b1 : hfill_r;

  assign busy      = (phase_r != lru2_pkg::PH_IDLE);
  assign cfg_ready = (phase_r == lru2_pkg::PH_IDLE);

  always_comb begin
    phase_nxt = phase_r;
    mfill_nxt = mfill_r;
    hfill_nxt = hfill_r;
    found_nxt = found_r;
    fdata_nxt = fdata_r;
    where_nxt = where_r;
    mop = lru2_pkg::OP_HOLD;
    hop = lru2_pkg::OP_HOLD;
    mpos = '0;
    mlast = '0;
    hpos = '0;
    hlast = '0;
    mhk = mv_key_r;
    mhd = mv_data_r;
    hhd = dat_r;
    unique case (phase_r)
      lru2_pkg::PH_IDLE: if (start) phase_nxt = lru2_pkg::PH_SEARCH;
      lru2_pkg::PH_SEARCH: begin
        found_nxt = 1'b0;
        fdata_nxt = '0;
        where_nxt = lru2_pkg::WHERE_NONE;
        phase_nxt = lru2_pkg::PH_DONE;
        if (cmd_r <= 3'(lru2_pkg::CMD_DELETE)) begin
          if (mfound) where_nxt = lru2_pkg::WHERE_MAIN;
          else if (hfound) where_nxt = lru2_pkg::WHERE_HIST;
          phase_nxt = lru2_pkg::PH_STEP1;
        end else if (cmd_r == 3'(lru2_pkg::CMD_CLEAR)) begin
          mfill_nxt = '0;
          hfill_nxt = '0;
          found_nxt = 1'b1;
        end
      end
      lru2_pkg::PH_STEP1: begin
        phase_nxt = lru2_pkg::PH_DONE;
        priority case (cmd_r)
          3'(lru2_pkg::CMD_INSERT), 3'(lru2_pkg::CMD_VISIT): begin
            found_nxt = mhit_r || hhit_r || (cmd_r == 3'(lru2_pkg::CMD_INSERT));
            if (mhit_r) begin
              fdata_nxt = (cmd_r == 3'(lru2_pkg::CMD_VISIT)) ? mv_data_r : '0;
              mop = lru2_pkg::OP_PULL;
              mpos = mi_r;
              mlast = MIW'(mfill_r - 1'b1);
              phase_nxt = lru2_pkg::PH_STEP2;
            end else if (hhit_r) begin
              fdata_nxt = (cmd_r == 3'(lru2_pkg::CMD_VISIT)) ? mv_data_r : '0;
              hop = lru2_pkg::OP_PULL;
              hpos = hi_r;
              hlast = HIW'(hfill_r - 1'b1);
              hfill_nxt = hfill_r - 1'b1;
              mfill_nxt = mfill_room;
              phase_nxt = lru2_pkg::PH_STEP2;
            end else if (cmd_r == 3'(lru2_pkg::CMD_INSERT)) begin
              hop = lru2_pkg::OP_PUSH;
              hpos = HIW'(hfill_room);
              hhd = dat_r;
              hfill_nxt = hfill_room + 1'b1;
            end else begin
              hfill_nxt = hfill_room;
            end
          end
          3'(lru2_pkg::CMD_GET): begin
            found_nxt = mhit_r;
            fdata_nxt = mhit_r ? mv_data_r : '0;
            if (!mhit_r) where_nxt = lru2_pkg::WHERE_NONE;
          end
          3'(lru2_pkg::CMD_UPDATE): begin
            found_nxt = mhit_r || hhit_r;
            if (mhit_r) begin
              mop = lru2_pkg::OP_WRITE;
              mpos = mi_r;
              mhd = dat_r;
            end else if (hhit_r) begin
              hop = lru2_pkg::OP_WRITE;
              hpos = hi_r;
            end
          end
          default: begin
            found_nxt = mhit_r || hhit_r;
            if (mhit_r) begin
              mop = lru2_pkg::OP_PULL;
              mpos = mi_r;
              mlast = MIW'(mfill_r - 1'b1);
              mfill_nxt = mfill_r - 1'b1;
            end else if (hhit_r) begin
              hop = lru2_pkg::OP_PULL;
              hpos = hi_r;
              hlast = HIW'(hfill_r - 1'b1);
              hfill_nxt = hfill_r - 1'b1;
            end
          end
        endcase
      end
      lru2_pkg::PH_STEP2: begin
        // Push the saved entry to the front of the main list.
        mop = lru2_pkg::OP_PUSH;
        mpos = mhit_r ? MIW'(mfill_r - 1'b1) : MIW'(mfill_r);
        if (!mhit_r) mfill_nxt = mfill_r + 1'b1;
        phase_nxt = lru2_pkg::PH_DONE;
      end
      lru2_pkg::PH_DONE: phase_nxt = lru2_pkg::PH_IDLE;
      default: phase_nxt = lru2_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lru2_pkg::PH_IDLE;
      mfill_r      <= '0;
      hfill_r      <= '0;
      lru_limit_r  <= 5'd16;
      hist_limit_r <= 6'd32;
      found_r      <= 1'b0;
      where_r      <= '0;
    end else begin
      phase_r <= phase_nxt;
      mfill_r <= mfill_nxt;
      hfill_r <= hfill_nxt;
      found_r <= found_nxt;
      where_r <= where_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lru2_pkg::CfgIdxW'(lru2_pkg::CfgIdxLru)) lru_limit_r <= cfg_data[4:0];
        else hist_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    fdata_r <= fdata_nxt;
    if (phase_r == lru2_pkg::PH_IDLE && start) begin
      cmd_r <= in_command;
      key_r <= in_item_key;
      dat_r <= in_item_data;
    end
    if (phase_r == lru2_pkg::PH_SEARCH) begin
      mhit_r <= mfound;
      hhit_r <= !mfound && hfound;
      mi_r   <= mfirst;
      hi_r   <= hfirst;
      mv_key_r  <= mfound ? mkeys[mfirst] : hkeys[hfirst];
      mv_data_r <= mfound ? mdatas[mfirst] : hdatas[hfirst];
    end
  end

  assign out_valid       = (phase_r == lru2_pkg::PH_DONE);
  assign out_found       = found_r;
  assign out_found_data  = fdata_r;
  assign out_found_where = where_r;

  lru2_list #(.DEPTH(LRU_DEPTH), .KW(KEY_WIDTH), .DW(DATA_WIDTH)) u_main (
    .clk(clk), .op(mop), .pos(mpos), .last(mlast), .head_key(mhk), .head_data(mhd),
    .search_key(key_r), .hits(mhits), .keys(mkeys), .datas(mdatas)
  );

  lru2_list #(.DEPTH(HIST_DEPTH), .KW(KEY_WIDTH), .DW(DATA_WIDTH)) u_hist (
    .clk(clk), .op(hop), .pos(hpos), .last(hlast), .head_key(key_r), .head_data(hhd),
    .search_key(key_r), .hits(hhits), .keys(hkeys), .datas(hdatas)
  );
endmodule
`default_nettype wire
